>>> hw/rtl/srmt_pkg.sv
// package with constants and types of the sorted read mark table unit
`default_nettype none
package srmt_pkg;
   localparam int DefaultDepth    = 256;
   localparam int DefaultKeyWidth = 16;
   localparam int CountWidth      = 16;
   localparam int DateWidth       = 32;
   localparam int RespWidth       = 17;

   localparam logic [2:0] OpLoad     = 3'd0;
   localparam logic [2:0] OpLookup   = 3'd1;
   localparam logic [2:0] OpUpdate   = 3'd2;
   localparam logic [2:0] OpReset    = 3'd3;
   localparam logic [2:0] OpMarkLost = 3'd4;
   localparam logic [2:0] OpDump     = 3'd5;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusFull     = 2'd1;
   localparam logic [1:0] StatusDisabled = 2'd2;
   localparam logic [1:0] StatusDumpDone = 2'd3;
endpackage
`default_nettype wire

>>> hw/rtl/srmt_mem.sv
// one-port-write, one-port-read table memory with registered read data
`default_nettype none
module srmt_mem
   import srmt_pkg::*;
#(
   parameter int Depth = DefaultDepth,
   parameter int Width = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> hw/rtl/sorted_read_mark_table_unit.sv
// top level of the sorted read mark table unit
//
// a table of read marks kept in order of item number, held in one memory
// req_ carries one operation per transaction, rsp_ returns exactly one result
// transaction for each; csr_ writes the table enable bit, which the user must
// do only while idle, as the block does not enforce it; each scanning operation
// walks the table one entry at a time (address, then data) through a memory
// whose read data arrives in the cycle after the address
// load, unused codes, a disabled table and an empty lost range: result valid
// the cycle after the request is taken
// lookup, update hit and reset stop at the first entry whose key is not below
// the request key, else scan every entry; an update that inserts moves the tail
// up one entry per read-then-write pair of states, then writes the new entry
// dump: visits every entry up to the next undeleted one
// one operation is in progress at a time; req_tready is low while it runs and
// rises the cycle after the result transaction has gone, so a new load is not
// taken before the result of the last one has gone
// the result waits in an output register; while rsp_tready is low the block
// holds it and takes no new request
// reset empties the table (entry count and dump cursor to zero) and clears
// the enable bit; memory contents need no clearing as only entries below
// the count are ever read
`default_nettype none
module sorted_read_mark_table_unit
   import srmt_pkg::*;
#(
   parameter int Depth    = DefaultDepth,
   parameter int KeyWidth = DefaultKeyWidth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // operation[2:0], item[18:3], last_item[35:19], resp[52:36], load_count[68:53],
   // load_forgotten[69], load_date[101:70], now[133:102], zero fill to 135
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], read_upto[18:2], is_forgotten[19], out_item[35:20],
   // out_count[51:36], out_forgotten[52], out_date[84:53], zero fill to 87
   output logic [87:0]       rsp_tdata,
   // last_entry
   output logic              rsp_tlast
);
   localparam int AW = $clog2(Depth);
   localparam int CW = AW + 1;
   // entry word: date, orig count, count, deleted, forgotten, key
   localparam int EW = KeyWidth + 2 + 2 * CountWidth + DateWidth;
   localparam int FO = KeyWidth;
   localparam int DO = KeyWidth + 1;
   localparam int CO = KeyWidth + 2;
   localparam int OO = CO + CountWidth;
   localparam int TO = OO + CountWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_ADDR, S_SCAN_DATA, S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_RESP
   } state_type;

   state_type          state_ff;
   logic               enable_ff;
   logic [CW-1:0]      total_ff, cursor_ff, idx_ff, pos_ff;
   logic [2:0]         op_ff;
   logic [KeyWidth-1:0] key_ff;
   logic signed [RespWidth-1:0] last_ff, resp_ff;
   logic               active_ff;
   logic [DateWidth-1:0] now_ff;
   logic [87:0]        rdata_ff;
   logic               rlast_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [EW-1:0]      wr_data, rd_data;

   srmt_mem #(.Depth(Depth), .Width(EW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [KeyWidth-1:0]  rkey;
   logic [CountWidth-1:0] cnt_sat;
   logic [KeyWidth-1:0]  in_key;
   logic [2:0]           req_op;
   assign rkey   = rd_data[KeyWidth-1:0];
   assign in_key = KeyWidth'(req_tdata[18:3]);
   assign req_op = req_tdata[2:0];

   always_comb begin
      if (resp_ff < 0) cnt_sat = '0;
      else if (resp_ff >= 17'sd65535) cnt_sat = '1;
      else cnt_sat = CountWidth'(resp_ff + 17'sd1);
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !rsp_tvalid;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;

   // decisions on a new request
   logic                 mark_early, load_go, idle_done;
   logic [1:0]           idle_status;
   logic [RespWidth-1:0] idle_upto;
   assign mark_early = req_op == OpMarkLost &&
                       $signed(req_tdata[35:19]) != -17'sd1 &&
                       $signed(req_tdata[35:19]) < $signed({1'b0, in_key});
   assign load_go    = enable_ff && req_op == OpLoad && total_ff < CW'(Depth);
   assign idle_done  = req_op > OpDump || !enable_ff || req_op == OpLoad || mark_early;
   assign idle_upto  = (req_op == OpLookup && !enable_ff) ? '1 : '0;

   always_comb begin
      idle_status = StatusOk;
      if (req_op <= OpDump) begin
         if (!enable_ff) idle_status = StatusDisabled;
         else if (req_op == OpLoad && total_ff >= CW'(Depth)) idle_status = StatusFull;
      end
   end

   // decisions on the entry just read during a scan
   logic                 key_gt, key_eq, mark_active, mark_stop, scan_stop, scan_active;
   logic [RespWidth-1:0] hit_upto, lookup_upto;
   logic                 lookup_forg;
   assign key_gt      = rkey > key_ff;
   assign key_eq      = rkey == key_ff;
   assign mark_active = active_ff || (rkey >= key_ff);
   assign mark_stop   = mark_active && last_ff != -17'sd1 && $signed({1'b0, rkey}) > last_ff;
   assign hit_upto    = {1'b0, rd_data[CO +: CountWidth]} - 17'd1;
   assign lookup_upto = key_eq ? hit_upto : '1;
   assign lookup_forg = key_eq & rd_data[FO];

   always_comb begin
      scan_stop   = 1'b1;
      scan_active = active_ff;
      case (op_ff)
         OpLookup, OpUpdate, OpReset: scan_stop = key_gt || key_eq;
         OpMarkLost: begin
            scan_stop   = mark_stop;
            scan_active = mark_active;
         end
         OpDump: begin
            scan_stop   = active_ff && !rd_data[DO];
            scan_active = active_ff || !rd_data[DO];
         end
         default: ;
      endcase
   end

   // in-place change of a hit entry or of an entry in the lost range
   logic [EW-1:0] mod_entry;
   always_comb begin
      mod_entry = rd_data;
      if (op_ff == OpReset) begin
         mod_entry[CO +: CountWidth] = rd_data[OO +: CountWidth];
      end else if (op_ff == OpMarkLost) begin
         mod_entry[DO] = 1'b1;
      end else if (resp_ff == -17'sd1) begin
         mod_entry[FO] = ~rd_data[FO];
      end else begin
         mod_entry[CO +: CountWidth] = cnt_sat;
         mod_entry[TO +: DateWidth]  = now_ff;
      end
   end

   // entry placed by an update of an absent key
   logic [EW-1:0] new_entry;
   assign new_entry = (resp_ff == -17'sd1) ?
      {{DateWidth{1'b0}}, {2*CountWidth{1'b0}}, 1'b0, 1'b1, key_ff} :
      {now_ff, {CountWidth{1'b0}}, cnt_sat, 1'b0, 1'b0, key_ff};

   // memory access steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            wr_en   = req_tvalid && req_tready && load_go;
            wr_addr = total_ff[AW-1:0];
            wr_data = {req_tdata[70 +: DateWidth], req_tdata[53 +: CountWidth],
                       req_tdata[53 +: CountWidth], 1'b0, req_tdata[69], in_key};
         end
         S_SCAN_DATA: begin
            wr_data = mod_entry;
            if (op_ff == OpUpdate || op_ff == OpReset) wr_en = key_eq;
            else if (op_ff == OpMarkLost) wr_en = mark_active && !mark_stop;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff + 1'b1);
            wr_data = rd_data;
         end
         S_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = new_entry;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         enable_ff <= 1'b0;
         total_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) enable_ff <= csr_data;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  op_ff     <= req_op;
                  key_ff    <= in_key;
                  last_ff   <= req_tdata[35:19];
                  resp_ff   <= req_tdata[52:36];
                  now_ff    <= req_tdata[133:102];
                  rdata_ff  <= {69'd0, idle_upto, idle_status};
                  rlast_ff  <= 1'b0;
                  active_ff <= 1'b0;
                  idx_ff    <= (req_op == OpDump) ? cursor_ff : '0;
                  if (load_go) total_ff <= total_ff + 1'b1;
                  state_ff  <= idle_done ? S_RESP : S_SCAN_ADDR;
               end
            end
            S_SCAN_ADDR: begin
               // address is presented this cycle, data next
               if (idx_ff < total_ff) begin
                  state_ff <= S_SCAN_DATA;
               end else if (op_ff == OpUpdate) begin
                  // key above every entry: new entry goes at the end
                  if (total_ff >= CW'(Depth)) begin
                     rdata_ff <= {rdata_ff[87:2], StatusFull};
                     state_ff <= S_RESP;
                  end else begin
                     pos_ff   <= idx_ff;
                     state_ff <= S_INSERT;
                  end
               end else begin
                  state_ff <= S_RESP;
                  if (op_ff == OpLookup) begin
                     rdata_ff <= {rdata_ff[87:19], {RespWidth{1'b1}}, rdata_ff[1:0]};
                  end else if (op_ff == OpDump && !active_ff) begin
                     // nothing left to give out: empty the table
                     rdata_ff  <= {rdata_ff[87:2], StatusDumpDone};
                     total_ff  <= '0;
                     cursor_ff <= '0;
                  end
               end
            end
            S_SCAN_DATA: begin
               if (!scan_stop) begin
                  idx_ff    <= idx_ff + 1'b1;
                  active_ff <= scan_active;
                  state_ff  <= S_SCAN_ADDR;
                  if (op_ff == OpDump && !active_ff && !rd_data[DO]) begin
                     // first undeleted entry: give it out, then look for another
                     rdata_ff  <= {3'b000, rd_data[TO +: DateWidth], rd_data[FO],
                                   rd_data[CO +: CountWidth], 16'(rd_data[KeyWidth-1:0]),
                                   rdata_ff[19:0]};
                     rlast_ff  <= 1'b1;
                     cursor_ff <= idx_ff + 1'b1;
                  end
               end else if (op_ff == OpUpdate && key_gt) begin
                  // absent key: open a slot here by moving the tail up
                  if (total_ff >= CW'(Depth)) begin
                     rdata_ff <= {rdata_ff[87:2], StatusFull};
                     state_ff <= S_RESP;
                  end else begin
                     pos_ff   <= idx_ff;
                     idx_ff   <= total_ff - 1'b1;
                     state_ff <= S_SHIFT_RD;
                  end
               end else begin
                  state_ff <= S_RESP;
                  if (op_ff == OpLookup) begin
                     rdata_ff <= {rdata_ff[87:20], lookup_forg, lookup_upto, rdata_ff[1:0]};
                  end
                  if (op_ff == OpDump) rlast_ff <= 1'b0;
               end
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               // entry idx is copied to idx+1 in this state
               if (idx_ff == pos_ff) begin
                  state_ff <= S_INSERT;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_INSERT: begin
               total_ff <= total_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready);
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(Depth));
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= total_ff);
endmodule
`default_nettype wire
